>>> hw/rtl/cll_pkg.sv
// shared types, constants and helpers for the combination lock
`timescale 1ns / 1ps

package cll_pkg;

   // digits per entry and derived widths
   localparam int CODE_LENGTH = 4;
   localparam int CNT_W       = $clog2(CODE_LENGTH + 1);
   localparam int DIGIT_W     = 3;
   localparam int TIMER_W     = 16;
   localparam int ERR_W       = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   // event kinds carried by a transaction
   typedef enum logic [1:0] {
      MODE_KEY    = 2'd0,
      MODE_CHANGE = 2'd1,
      MODE_TICK   = 2'd2,
      MODE_IDLE   = 2'd3
   } mode_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENTRY_TIMEOUT = 2'd0,
      CSR_GRACE         = 2'd1,
      CSR_LOCKOUT       = 2'd2,
      CSR_MAX_ERRORS    = 2'd3
   } csr_idx_type;

   localparam logic [DIGIT_W-1:0] DIGIT_MIN = 3'd1;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 3'd4;
   localparam logic [ERR_W-1:0]   ERR_SAT   = 2'd3;

   localparam logic [TIMER_W-1:0] ENTRY_TIMEOUT_RST = 16'd10;
   localparam logic [TIMER_W-1:0] GRACE_RST         = 16'd60;
   localparam logic [TIMER_W-1:0] LOCKOUT_RST       = 16'd300;
   localparam logic [ERR_W-1:0]   MAX_ERRORS_RST    = 2'd3;

   typedef logic [DIGIT_W-1:0] code_type [CODE_LENGTH];

   // factory code 1,2,3,4 repeating
   function automatic logic [DIGIT_W-1:0] default_digit(input int pos);
      logic [1:0] sel;
      sel = 2'(pos);
      return DIGIT_W'({1'b0, sel} + 3'd1);
   endfunction

   // timer step: true when the advanced count reaches the limit
   function automatic logic timer_expires(input logic [TIMER_W-1:0] count,
                                          input logic [TIMER_W-1:0] limit);
      logic [TIMER_W:0] nxt;
      nxt = {1'b0, count} + 1'b1;
      return nxt >= {1'b0, limit};
   endfunction

endpackage

>>> hw/rtl/combination_lock_with_lockout.sv
// keypad combination lock with error count and lockout
// a request is held in the input register, and its response is then held in the response register
// throughput: one event per cycle while the response channel is not stalled; input register and
//    response register each hold one transaction and move whenever the next stage is free
// reset: synchronous active-high; code returns to 1,2,3,4, lock closed, all timers idle,
//    configuration back to timeout 10, grace 60, lockout 300, max errors 3
`timescale 1ns / 1ps

module combination_lock_with_lockout (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic [cll_pkg::DIGIT_W-1:0]         req_digit,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_lock_open,
   output logic                                rsp_wrong_entry,
   output logic                                rsp_code_changed,
   output logic                                rsp_locked_out,
   output logic                                rsp_change_pending,
   output logic [1:0]                          rsp_entry_count,
   // configuration write port
   input  logic                                csr_we,
   input  logic [cll_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cll_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // configuration registers
   logic [cll_pkg::TIMER_W-1:0] cfg_entry_to_ff;
   logic [cll_pkg::TIMER_W-1:0] cfg_grace_ff;
   logic [cll_pkg::TIMER_W-1:0] cfg_lockout_ff;
   logic [cll_pkg::ERR_W-1:0]   cfg_max_err_ff;

   // input register
   logic                          in_valid_ff;
   cll_pkg::mode_type             in_mode_ff;
   logic [cll_pkg::DIGIT_W-1:0]   in_digit_ff;

   // lock state
   cll_pkg::code_type             code_ff,    code_in;
   cll_pkg::code_type             entry_ff,   entry_in;
   logic [cll_pkg::CNT_W-1:0]     cnt_ff,     cnt_in;
   logic [cll_pkg::TIMER_W-1:0]   ent_tmr_ff, ent_tmr_in;
   logic                          ent_act_ff, ent_act_in;
   logic                          chg_ff,     chg_in;
   logic                          lock_ff,    lock_in;
   logic [cll_pkg::ERR_W-1:0]     err_ff,     err_in;
   logic [cll_pkg::TIMER_W-1:0]   grc_tmr_ff, grc_tmr_in;
   logic                          grc_act_ff, grc_act_in;
   logic [cll_pkg::TIMER_W-1:0]   lko_tmr_ff, lko_tmr_in;
   logic                          lko_act_ff, lko_act_in;

   // response register
   logic                          rsp_valid_ff;
   logic                          wrong_ff, wrong_in;
   logic                          changed_ff, changed_in;

   logic                          advance;
   logic                          digit_ok;
   logic                          match;
   logic [cll_pkg::ERR_W-1:0]     err_limit;
   logic [cll_pkg::CNT_W-1:0]     cnt_inc;

   // the event in the input register moves to the response register when that is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign digit_ok  = (in_digit_ff >= cll_pkg::DIGIT_MIN) && (in_digit_ff <= cll_pkg::DIGIT_MAX);
   // zero max_errors acts as one
   assign err_limit = (cfg_max_err_ff == '0) ? cll_pkg::ERR_W'(1) : cfg_max_err_ff;
   assign cnt_inc   = cll_pkg::CNT_W'(cnt_ff + 1'b1);

   // next state for one event
   always_comb begin
      code_in    = code_ff;
      entry_in   = entry_ff;
      cnt_in     = cnt_ff;
      ent_tmr_in = ent_tmr_ff;
      ent_act_in = ent_act_ff;
      chg_in     = chg_ff;
      lock_in    = lock_ff;
      err_in     = err_ff;
      grc_tmr_in = grc_tmr_ff;
      grc_act_in = grc_act_ff;
      lko_tmr_in = lko_tmr_ff;
      lko_act_in = lko_act_ff;
      wrong_in   = 1'b0;
      changed_in = 1'b0;
      match      = 1'b1;

      unique case (in_mode_ff)
         cll_pkg::MODE_KEY: begin
            if (!lko_act_ff && digit_ok) begin
               // first digit starts the entry timer
               if (cnt_ff == '0) begin
                  ent_tmr_in = '0;
                  ent_act_in = 1'b1;
               end
               for (int i = 0; i < cll_pkg::CODE_LENGTH; i++) begin
                  if (cnt_ff == cll_pkg::CNT_W'(i)) entry_in[i] = in_digit_ff;
               end
               cnt_in = cnt_inc;
               if (cnt_inc == cll_pkg::CNT_W'(cll_pkg::CODE_LENGTH)) begin
                  // full entry: store new code or compare against stored one
                  for (int i = 0; i < cll_pkg::CODE_LENGTH; i++) begin
                     if (entry_in[i] != code_ff[i]) match = 1'b0;
                  end
                  if (chg_ff) begin
                     code_in    = entry_in;
                     chg_in     = 1'b0;
                     changed_in = 1'b1;
                  end else if (match) begin
                     lock_in = !lock_ff;
                  end else begin
                     wrong_in = 1'b1;
                     if (err_ff != cll_pkg::ERR_SAT) err_in = err_ff + 1'b1;
                     // grace window opens only on the first error
                     if (!grc_act_ff) begin
                        grc_act_in = 1'b1;
                        grc_tmr_in = '0;
                     end
                     if (err_in >= err_limit) begin
                        grc_act_in = 1'b0;
                        grc_tmr_in = '0;
                        lko_act_in = 1'b1;
                        lko_tmr_in = '0;
                     end
                  end
                  for (int i = 0; i < cll_pkg::CODE_LENGTH; i++) entry_in[i] = '0;
                  cnt_in     = '0;
                  ent_tmr_in = '0;
                  ent_act_in = 1'b0;
               end
            end
         end
         cll_pkg::MODE_CHANGE: begin
            // discard partial entry and arm code change
            if (!lko_act_ff) begin
               for (int i = 0; i < cll_pkg::CODE_LENGTH; i++) entry_in[i] = '0;
               cnt_in     = '0;
               ent_tmr_in = '0;
               ent_act_in = 1'b0;
               chg_in     = 1'b1;
            end
         end
         cll_pkg::MODE_TICK: begin
            if (ent_act_ff) begin
               if (cll_pkg::timer_expires(ent_tmr_ff, cfg_entry_to_ff)) begin
                  for (int i = 0; i < cll_pkg::CODE_LENGTH; i++) entry_in[i] = '0;
                  cnt_in     = '0;
                  ent_tmr_in = '0;
                  ent_act_in = 1'b0;
               end else begin
                  ent_tmr_in = ent_tmr_ff + 1'b1;
               end
            end
            if (grc_act_ff) begin
               if (cll_pkg::timer_expires(grc_tmr_ff, cfg_grace_ff)) begin
                  grc_act_in = 1'b0;
                  grc_tmr_in = '0;
                  err_in     = '0;
               end else begin
                  grc_tmr_in = grc_tmr_ff + 1'b1;
               end
            end
            if (lko_act_ff) begin
               if (cll_pkg::timer_expires(lko_tmr_ff, cfg_lockout_ff)) begin
                  lko_act_in = 1'b0;
                  lko_tmr_in = '0;
                  err_in     = '0;
               end else begin
                  lko_tmr_in = lko_tmr_ff + 1'b1;
               end
            end
         end
         cll_pkg::MODE_IDLE: begin
            // no effect
         end
         default: begin
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_entry_to_ff <= cll_pkg::ENTRY_TIMEOUT_RST;
         cfg_grace_ff    <= cll_pkg::GRACE_RST;
         cfg_lockout_ff  <= cll_pkg::LOCKOUT_RST;
         cfg_max_err_ff  <= cll_pkg::MAX_ERRORS_RST;
      end else if (csr_we) begin
         unique case (cll_pkg::csr_idx_type'(csr_index))
            cll_pkg::CSR_ENTRY_TIMEOUT: cfg_entry_to_ff <= csr_wdata;
            cll_pkg::CSR_GRACE:         cfg_grace_ff    <= csr_wdata;
            cll_pkg::CSR_LOCKOUT:       cfg_lockout_ff  <= csr_wdata;
            cll_pkg::CSR_MAX_ERRORS:    cfg_max_err_ff  <= csr_wdata[cll_pkg::ERR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // input register control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_mode_ff  <= cll_pkg::mode_type'(req_mode);
         in_digit_ff <= req_digit;
      end
   end

   // lock state, updated once per event in order
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cll_pkg::CODE_LENGTH; i++) begin
            code_ff[i]  <= cll_pkg::default_digit(i);
            entry_ff[i] <= '0;
         end
         cnt_ff     <= '0;
         ent_tmr_ff <= '0;
         ent_act_ff <= 1'b0;
         chg_ff     <= 1'b0;
         lock_ff    <= 1'b0;
         err_ff     <= '0;
         grc_tmr_ff <= '0;
         grc_act_ff <= 1'b0;
         lko_tmr_ff <= '0;
         lko_act_ff <= 1'b0;
      end else if (advance) begin
         code_ff    <= code_in;
         entry_ff   <= entry_in;
         cnt_ff     <= cnt_in;
         ent_tmr_ff <= ent_tmr_in;
         ent_act_ff <= ent_act_in;
         chg_ff     <= chg_in;
         lock_ff    <= lock_in;
         err_ff     <= err_in;
         grc_tmr_ff <= grc_tmr_in;
         grc_act_ff <= grc_act_in;
         lko_tmr_ff <= lko_tmr_in;
         lko_act_ff <= lko_act_in;
      end
   end

   // response register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // per-event flags; the rest of the response is the state register itself
   always_ff @(posedge clock) begin
      if (advance) begin
         wrong_ff   <= wrong_in;
         changed_ff <= changed_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_lock_open      = lock_ff;
   assign rsp_wrong_entry    = wrong_ff;
   assign rsp_code_changed   = changed_ff;
   assign rsp_locked_out     = lko_act_ff;
   assign rsp_change_pending = chg_ff;
   assign rsp_entry_count    = 2'(cnt_ff);

endmodule

>>> tb/combination_lock_with_lockout_tb.sv
// self-checking testbench for the keypad combination lock with error lockout
`timescale 1ns / 1ps

module combination_lock_with_lockout_tb;

   // quiet cycles allowed before the run is declared hung; far above the
   // longest receiver stall plus the longest sender gap plus pipeline latency
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int CODE_BITS      = cll_pkg::CODE_LENGTH * cll_pkg::DIGIT_W;

   // one response transaction, laid out in port order
   typedef struct packed {
      logic       lock_open;
      logic       wrong_entry;
      logic       code_changed;
      logic       locked_out;
      logic       change_pending;
      logic [1:0] entry_count;
   } lock_status_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_valid  = 1'b0;
   logic                           req_stall;
   logic [1:0]                     req_mode   = cll_pkg::MODE_IDLE;
   logic [cll_pkg::DIGIT_W-1:0]    req_digit  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall  = 1'b0;
   logic                           rsp_lock_open;
   logic                           rsp_wrong_entry;
   logic                           rsp_code_changed;
   logic                           rsp_locked_out;
   logic                           rsp_change_pending;
   logic [1:0]                     rsp_entry_count;
   logic                           csr_we     = 1'b0;
   logic [cll_pkg::CSR_IDX_W-1:0]  csr_index  = cll_pkg::CSR_ENTRY_TIMEOUT;
   logic [cll_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   combination_lock_with_lockout dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_digit          (req_digit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_lock_open      (rsp_lock_open),
      .rsp_wrong_entry    (rsp_wrong_entry),
      .rsp_code_changed   (rsp_code_changed),
      .rsp_locked_out     (rsp_locked_out),
      .rsp_change_pending (rsp_change_pending),
      .rsp_entry_count    (rsp_entry_count),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // lock predictor state: its own copy of the code, entry, timers and csrs
   // ---------------------------------------------------------------------
   logic [cll_pkg::DIGIT_W-1:0] model_code  [cll_pkg::CODE_LENGTH];
   logic [cll_pkg::DIGIT_W-1:0] model_entry [cll_pkg::CODE_LENGTH];
   int unsigned                 model_count;
   logic [cll_pkg::TIMER_W-1:0] entry_age, grace_age, lockout_age;
   logic                        entry_running, grace_running, lockout_running;
   logic                        change_armed, lock_is_open;
   logic [cll_pkg::ERR_W-1:0]   error_tally;

   logic [cll_pkg::TIMER_W-1:0] cfg_entry_timeout = cll_pkg::ENTRY_TIMEOUT_RST;
   logic [cll_pkg::TIMER_W-1:0] cfg_grace         = cll_pkg::GRACE_RST;
   logic [cll_pkg::TIMER_W-1:0] cfg_lockout       = cll_pkg::LOCKOUT_RST;
   logic [cll_pkg::ERR_W-1:0]   cfg_max_errors    = cll_pkg::MAX_ERRORS_RST;

   // expected responses, oldest first
   lock_status_type pending_status [$];

   // bookkeeping for the summary
   int items_sent, responses_checked, mismatch_count, settings_used;
   int toggles_seen, wrong_seen, changes_seen, lockouts_seen, timeouts_seen;

   // idling knobs: percent chance of a sender gap / receiver stall
   int gap_pct   = 0;
   int stall_pct = 0;
   int stall_left;
   int quiet_cycles;

   // a timer advanced by one tick reaches its limit (zero acts as one)
   function automatic logic tick_expires(logic [cll_pkg::TIMER_W-1:0] age,
                                         logic [cll_pkg::TIMER_W-1:0] limit);
      return ({1'b0, age} + 1'b1) >= {1'b0, limit};
   endfunction

   function automatic void clear_entry();
      int i;
      for (i = 0; i < cll_pkg::CODE_LENGTH; i++) model_entry[i] = '0;
      model_count   = 0;
      entry_age     = '0;
      entry_running = 1'b0;
   endfunction

   function automatic void reset_lock_model();
      int i;
      for (i = 0; i < cll_pkg::CODE_LENGTH; i++)
         model_code[i] = cll_pkg::DIGIT_W'(i % 4 + 1);
      clear_entry();
      change_armed    = 1'b0;
      lock_is_open    = 1'b0;
      error_tally     = '0;
      grace_age       = '0;
      grace_running   = 1'b0;
      lockout_age     = '0;
      lockout_running = 1'b0;
   endfunction

   // apply one event to the predicted lock and return the status it reports
   function automatic lock_status_type lock_next_status(cll_pkg::mode_type m,
                                                        logic [cll_pkg::DIGIT_W-1:0] d);
      lock_status_type           st;
      logic                      wrong, changed, match;
      logic [cll_pkg::ERR_W-1:0] limit;
      int                        i;
      wrong   = 1'b0;
      changed = 1'b0;
      unique case (m)
         cll_pkg::MODE_KEY: begin
            // out-of-range digits and presses during lockout do nothing
            if (!lockout_running && d >= cll_pkg::DIGIT_MIN && d <= cll_pkg::DIGIT_MAX &&
                model_count < cll_pkg::CODE_LENGTH) begin
               if (model_count == 0) begin
                  entry_age     = '0;
                  entry_running = 1'b1;
               end
               model_entry[model_count] = d;
               model_count++;
               if (model_count == cll_pkg::CODE_LENGTH) begin
                  if (change_armed) begin
                     model_code   = model_entry;
                     change_armed = 1'b0;
                     changed      = 1'b1;
                     changes_seen++;
                  end else begin
                     match = 1'b1;
                     for (i = 0; i < cll_pkg::CODE_LENGTH; i++)
                        if (model_entry[i] != model_code[i]) match = 1'b0;
                     if (match) begin
                        // a good code leaves the error tally alone
                        lock_is_open = !lock_is_open;
                        toggles_seen++;
                     end else begin
                        wrong = 1'b1;
                        wrong_seen++;
                        if (error_tally < cll_pkg::ERR_SAT) error_tally++;
                        // the grace window is opened once, never restarted
                        if (!grace_running) begin
                           grace_running = 1'b1;
                           grace_age     = '0;
                        end
                        limit = (cfg_max_errors == '0) ? cll_pkg::ERR_W'(1) : cfg_max_errors;
                        if (error_tally >= limit) begin
                           grace_running   = 1'b0;
                           grace_age       = '0;
                           lockout_running = 1'b1;
                           lockout_age     = '0;
                           lockouts_seen++;
                        end
                     end
                  end
                  clear_entry();
               end
            end
         end
         cll_pkg::MODE_CHANGE: begin
            // drops any partial entry and arms a code change
            if (!lockout_running) begin
               clear_entry();
               change_armed = 1'b1;
            end
         end
         cll_pkg::MODE_TICK: begin
            // every running timer advances, even during lockout
            if (entry_running) begin
               if (tick_expires(entry_age, cfg_entry_timeout)) begin
                  clear_entry();
                  timeouts_seen++;
               end else begin
                  entry_age++;
               end
            end
            if (grace_running) begin
               if (tick_expires(grace_age, cfg_grace)) begin
                  grace_running = 1'b0;
                  grace_age     = '0;
                  error_tally   = '0;
               end else begin
                  grace_age++;
               end
            end
            if (lockout_running) begin
               if (tick_expires(lockout_age, cfg_lockout)) begin
                  lockout_running = 1'b0;
                  lockout_age     = '0;
                  error_tally     = '0;
               end else begin
                  lockout_age++;
               end
            end
         end
         default: ;  // idle event
      endcase
      st.lock_open      = lock_is_open;
      st.wrong_entry    = wrong;
      st.code_changed   = changed;
      st.locked_out     = lockout_running;
      st.change_pending = change_armed;
      st.entry_count    = 2'(model_count);
      return st;
   endfunction

   // ---------------------------------------------------------------------
   // idling
   // ---------------------------------------------------------------------

   // mostly short idles, now and then a long one
   function automatic int idle_length();
      if ($urandom_range(9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // zero appears often so that stretches without idling occur
   function automatic int pick_idle_pct();
      unique case ($urandom_range(4))
         0, 1:    return 0;
         2:       return 10;
         3:       return 30;
         default: return 60;
      endcase
   endfunction

   // receiver stalls at random
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left--;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left = idle_length() - 1;
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // response checking
   // ---------------------------------------------------------------------
   function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
         $display("t=%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      lock_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            $display("t=%0t unexpected response: expected none, actual %b", $time,
                     {rsp_lock_open, rsp_wrong_entry, rsp_code_changed, rsp_locked_out,
                      rsp_change_pending, rsp_entry_count});
            mismatch_count++;
         end else begin
            want = pending_status.pop_front();
            check_field("lock_open",      2'(want.lock_open),      2'(rsp_lock_open));
            check_field("wrong_entry",    2'(want.wrong_entry),    2'(rsp_wrong_entry));
            check_field("code_changed",   2'(want.code_changed),   2'(rsp_code_changed));
            check_field("locked_out",     2'(want.locked_out),     2'(rsp_locked_out));
            check_field("change_pending", 2'(want.change_pending), 2'(rsp_change_pending));
            check_field("entry_count",    want.entry_count,        rsp_entry_count);
            responses_checked++;
         end
      end
   end

   // hang detection: cycles with no transaction on either channel and no configuration write
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("t=%0t timeout: no transaction for %0d cycles, %0d responses outstanding",
                  $time, WATCHDOG_LIMIT, pending_status.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // one request transaction; the expectation is formed at the accepting edge
   task automatic send_event(cll_pkg::mode_type m, logic [cll_pkg::DIGIT_W-1:0] d);
      int gap;
      req_valid <= 1'b1;
      req_mode  <= m;
      req_digit <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_status.push_back(lock_next_status(m, d));
      items_sent++;
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         gap = idle_length();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until every expected response has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // write all four registers back to back; only called while idle
   task automatic program_lock(logic [cll_pkg::TIMER_W-1:0] entry_timeout,
                               logic [cll_pkg::TIMER_W-1:0] grace,
                               logic [cll_pkg::TIMER_W-1:0] lockout,
                               logic [cll_pkg::CSR_DATA_W-1:0] max_errors_word);
      cll_pkg::csr_idx_type           idx;
      logic [cll_pkg::CSR_DATA_W-1:0] word;
      int                             n;
      for (n = 0; n < 4; n++) begin
         idx = cll_pkg::csr_idx_type'(n);
         unique case (idx)
            cll_pkg::CSR_ENTRY_TIMEOUT: begin
               word              = entry_timeout;
               cfg_entry_timeout = entry_timeout;
            end
            cll_pkg::CSR_GRACE: begin
               word      = grace;
               cfg_grace = grace;
            end
            cll_pkg::CSR_LOCKOUT: begin
               word        = lockout;
               cfg_lockout = lockout;
            end
            default: begin
               word           = max_errors_word;
               cfg_max_errors = max_errors_word[cll_pkg::ERR_W-1:0];
            end
         endcase
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= word;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // four key presses, first digit in the top bits; ticks may slip in between
   task automatic key_sequence(logic [CODE_BITS-1:0] code_word, int tick_pct);
      int i;
      for (i = cll_pkg::CODE_LENGTH - 1; i >= 0; i--) begin
         if (tick_pct != 0 && $urandom_range(99) < tick_pct)
            send_event(cll_pkg::MODE_TICK, cll_pkg::DIGIT_W'($urandom_range(7)));
         send_event(cll_pkg::MODE_KEY, code_word[i*cll_pkg::DIGIT_W +: cll_pkg::DIGIT_W]);
      end
   endtask

   // the currently stored code, or a random legal one
   function automatic logic [CODE_BITS-1:0] code_word(bit stored);
      logic [CODE_BITS-1:0] w;
      int                   i;
      for (i = 0; i < cll_pkg::CODE_LENGTH; i++)
         w[(cll_pkg::CODE_LENGTH-1-i)*cll_pkg::DIGIT_W +: cll_pkg::DIGIT_W] =
            stored ? model_code[i] : cll_pkg::DIGIT_W'($urandom_range(1, 4));
      return w;
   endfunction

   // mostly well-formed entries with random content, plus ticks and noise
   task automatic random_events(int count, int burst_max);
      int start_count, kind, n;
      start_count = items_sent;
      gap_pct     = pick_idle_pct();
      stall_pct   = pick_idle_pct();
      while (items_sent - start_count < count) begin
         if ($urandom_range(39) == 0) begin
            gap_pct   = pick_idle_pct();
            stall_pct = pick_idle_pct();
         end
         kind = $urandom_range(99);
         // keep lockouts from swallowing the whole phase
         if (lockout_running && $urandom_range(1) == 0) kind = 70;
         if (kind < 35) begin
            key_sequence(code_word(1'b1), 6);
         end else if (kind < 55) begin
            key_sequence(code_word(1'b0), 6);
         end else if (kind < 65) begin
            send_event(cll_pkg::MODE_CHANGE, cll_pkg::DIGIT_W'($urandom_range(7)));
            key_sequence(code_word(1'b0), 6);
         end else if (kind < 82) begin
            repeat ($urandom_range(1, burst_max))
               send_event(cll_pkg::MODE_TICK, cll_pkg::DIGIT_W'($urandom_range(7)));
         end else if (kind < 92) begin
            // broken entry: a few digits and then something else
            n = $urandom_range(1, cll_pkg::CODE_LENGTH - 1);
            repeat (n)
               send_event(cll_pkg::MODE_KEY, cll_pkg::DIGIT_W'($urandom_range(1, 4)));
            send_event(cll_pkg::mode_type'($urandom_range(1, 3)),
                       cll_pkg::DIGIT_W'($urandom_range(7)));
         end else begin
            send_event(cll_pkg::mode_type'($urandom_range(3)),
                       cll_pkg::DIGIT_W'($urandom_range(7)));
         end
      end
      wait_for_results();
   endtask

   // ---------------------------------------------------------------------
   // directed tests
   // ---------------------------------------------------------------------

   // bad digits, idle mode and a one-tick entry timeout (zero register)
   task automatic test_ignored_events_and_timeout();
      gap_pct   = 30;
      stall_pct = 30;
      program_lock(16'd0, 16'd2, 16'd1, cll_pkg::CSR_DATA_W'(3));
      send_event(cll_pkg::MODE_KEY, 3'd0);
      send_event(cll_pkg::MODE_KEY, 3'd7);
      send_event(cll_pkg::MODE_IDLE, 3'd5);
      send_event(cll_pkg::MODE_KEY, 3'd1);
      send_event(cll_pkg::MODE_TICK, 3'd6);
   endtask

   // factory code opens, change button drops a partial entry, new code stored
   task automatic test_open_and_code_change();
      key_sequence({3'd1, 3'd2, 3'd3, 3'd4}, 0);
      send_event(cll_pkg::MODE_KEY, 3'd3);
      send_event(cll_pkg::MODE_CHANGE, 3'd7);
      key_sequence({3'd4, 3'd3, 3'd2, 3'd1}, 0);
   endtask

   // wrong entries count up within one grace window; a good code in between
   // closes the lock without clearing the count
   task automatic test_errors_within_grace();
      key_sequence({3'd1, 3'd1, 3'd1, 3'd1}, 0);
      send_event(cll_pkg::MODE_TICK, 3'd0);
      key_sequence({3'd4, 3'd3, 3'd2, 3'd1}, 0);
      key_sequence({3'd2, 3'd2, 3'd2, 3'd2}, 0);
      wait_for_results();
   endtask

   // zero error limit acts as one; presses ignored until the lockout ends
   task automatic test_lockout_zero_limit();
      program_lock(16'hFFFF, 16'hFFFF, 16'd1, cll_pkg::CSR_DATA_W'(0));
      key_sequence({3'd4, 3'd4, 3'd4, 3'd4}, 0);
      send_event(cll_pkg::MODE_KEY, 3'd4);
      send_event(cll_pkg::MODE_CHANGE, 3'd2);
      send_event(cll_pkg::MODE_TICK, 3'd5);
      send_event(cll_pkg::MODE_KEY, 3'd1);
      wait_for_results();
   endtask

   // ---------------------------------------------------------------------
   // random tests
   // ---------------------------------------------------------------------
   task automatic test_random_reset_values();
      program_lock(cll_pkg::ENTRY_TIMEOUT_RST, cll_pkg::GRACE_RST, cll_pkg::LOCKOUT_RST,
                   cll_pkg::CSR_DATA_W'(cll_pkg::MAX_ERRORS_RST));
      random_events(250, 40);
   endtask

   task automatic test_random_tight_timers();
      program_lock(16'd3, 16'd5, 16'd8, cll_pkg::CSR_DATA_W'(1));
      random_events(250, 10);
   endtask

   task automatic test_random_unit_timers();
      program_lock(16'd1, 16'd1, 16'd1, cll_pkg::CSR_DATA_W'(2));
      random_events(250, 4);
   endtask

   // widest timers: the lockout never ends here, so the phase stays short
   task automatic test_random_wide_timers();
      program_lock(16'hFFFF, 16'hFFFF, 16'hFFFF, cll_pkg::CSR_DATA_W'(3));
      random_events(120, 12);
   endtask

   // random settings; junk in the upper bits of the error limit word
   task automatic test_random_mixed_settings();
      logic [cll_pkg::CSR_DATA_W-1:0] limit_word;
      int                             k;
      for (k = 0; k < 4; k++) begin
         limit_word = cll_pkg::CSR_DATA_W'($urandom_range(16'hFFFF)) &
                      ~cll_pkg::CSR_DATA_W'(3);
         limit_word = limit_word | cll_pkg::CSR_DATA_W'($urandom_range(1, 3));
         program_lock(cll_pkg::TIMER_W'($urandom_range(1, 12)),
                      cll_pkg::TIMER_W'($urandom_range(1, 40)),
                      cll_pkg::TIMER_W'($urandom_range(1, 30)),
                      limit_word);
         random_events(150, 12);
      end
   endtask

   initial begin
      reset_lock_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ignored_events_and_timeout();
      test_open_and_code_change();
      test_errors_within_grace();
      test_lockout_zero_limit();
      test_random_reset_values();
      test_random_tight_timers();
      test_random_unit_timers();
      test_random_wide_timers();
      test_random_mixed_settings();

      // drained already; let the pipeline settle so that any strays still show up
      wait_for_results();
      repeat (6) @(posedge clock);

      $display("ran %0d events under %0d register settings, %0d responses checked",
               items_sent, settings_used, responses_checked);
      $display("saw %0d lock toggles, %0d wrong entries, %0d code changes,",
               toggles_seen, wrong_seen, changes_seen);
      $display("    %0d lockouts, %0d entry timeouts", lockouts_seen, timeouts_seen);
      if (mismatch_count == 0 && pending_status.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> combination_lock_with_lockout.f
hw/rtl/cll_pkg.sv
hw/rtl/combination_lock_with_lockout.sv
tb/combination_lock_with_lockout_tb.sv
